>>> rtl/dpf_pkg.sv
// shared types and constants of the distinct prime factorizer
`timescale 1ns / 1ps
package dpf_pkg;

  localparam int VALUE_W     = 16;
  localparam int INDEX_W     = 13;
  localparam int MAX_RESULTS = 6;
  localparam int NUM_W       = 3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_SV_RD,
    ST_SV_TEST,
    ST_SV_MARK,
    ST_IDLE,
    ST_NEXT,
    ST_PR_RD,
    ST_PR_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT,
    ST_FINAL
  } state_e;

endpackage

>>> rtl/dpf_div.sv
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module dpf_div
  import dpf_pkg::*;
#(
  parameter int DIV_W = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [VALUE_W-1:0]   dividend_i,
  input  logic [DIV_W-1:0]     divisor_i,
  output logic                 done_o,
  output logic [VALUE_W-1:0]   quot_o,
  output logic                 rem_zero_o
);

  localparam int CNT_W = $clog2(VALUE_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [DIV_W:0]     r_q, r_d;
  logic [VALUE_W-1:0] q_q, q_d;
  logic [DIV_W:0]     trial;

  always_comb begin
    trial  = {r_q[DIV_W-1:0], q_q[VALUE_W-1]};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    q_d    = q_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      r_d    = '0;
      q_d    = dividend_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, divisor_i}) begin
        r_d = trial - {1'b0, divisor_i};
        q_d = {q_q[VALUE_W-2:0], 1'b1};
      end else begin
        r_d = trial;
        q_d = {q_q[VALUE_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(VALUE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    q_q <= q_d;
  end

  assign done_o     = done_q;
  assign quot_o     = q_q;
  assign rem_zero_o = (r_q == '0);

endmodule

>>> rtl/distinct_prime_factorizer_core.sv
// distinct prime factorizer: sieve at reset, then trial division per word
// after reset the composite map is cleared and then sieved, each prime p marking its multiples
// up to MAX_VALUE; no word is taken meanwhile
// per word: each prime tried is read from the list and tested by a division (one more
// per power divided out); up to MAX_RESULTS factors are emitted, and a last output ends it
// one word at a time; reset clears all control state and restarts the sieve
`timescale 1ns / 1ps
module distinct_prime_factorizer_core
  import dpf_pkg::*;
#(
  parameter int MAX_VALUE   = 65535,
  parameter int PRIME_DEPTH = 8192
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [VALUE_W-1:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [INDEX_W-1:0] prime_index_o,
  output logic [VALUE_W-1:0] prime_value_o,
  output logic               has_factor_o,
  output logic               last_o
);

  localparam int VAL_W = $clog2(MAX_VALUE + 1);
  localparam int DIV_W = (VAL_W > VALUE_W) ? VAL_W : VALUE_W;
  localparam int IDX_W = $clog2(PRIME_DEPTH);
  localparam int CNT_W = $clog2(PRIME_DEPTH + 1);
  localparam logic [VAL_W:0] MaxL   = (VAL_W + 1)'(MAX_VALUE);
  localparam logic [CNT_W-1:0] DepL = CNT_W'(PRIME_DEPTH);

  state_e state_q, state_d;

  logic [VAL_W:0]     i_q, i_d;
  logic [VAL_W:0]     j_q, j_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   k_q, k_d;
  logic [VALUE_W-1:0] rem_q, rem_d;
  logic [VAL_W-1:0]   p_q, p_d;
  logic               found_q, found_d;
  logic [NUM_W-1:0]   n_q, n_d;
  logic               pend_v_q, pend_v_d;
  logic [CNT_W-1:0]   pend_k_q, pend_k_d;
  logic [VAL_W-1:0]   pend_p_q, pend_p_d;

  logic               out_v_q, out_v_d;
  logic [INDEX_W-1:0] out_idx_q, out_idx_d;
  logic [VALUE_W-1:0] out_val_q, out_val_d;
  logic               out_has_q, out_has_d;
  logic               out_last_q, out_last_d;
  logic               out_free;

  logic               map_mem [MAX_VALUE+1];
  logic               map_we, map_wd, map_rdata;
  logic [VAL_W-1:0]   map_wa, map_ra;

  logic [VAL_W-1:0]   plist_mem [PRIME_DEPTH];
  logic               pl_we;
  logic [VAL_W-1:0]   pl_rdata;

  logic               div_start, div_done, div_rz;
  logic [VALUE_W-1:0] div_quot;

  logic [VAL_W:0]     i_twice, j_next;
  logic               cont;

  assign out_free = !out_v_q || !out_stall_i;
  assign i_twice  = i_q + i_q;
  assign j_next   = j_q + i_q;
  assign cont     = (k_q < cnt_q) && (rem_q > VALUE_W'(1)) && (n_q < NUM_W'(MAX_RESULTS));

  // composite map
  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_rdata <= map_mem[map_ra];
  end

  // prime list
  always_ff @(posedge clk_i) begin
    if (pl_we) begin
      plist_mem[cnt_q[IDX_W-1:0]] <= i_q[VAL_W-1:0];
    end
    pl_rdata <= plist_mem[k_q[IDX_W-1:0]];
  end

  dpf_div #(
    .DIV_W(DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rem_q),
    .divisor_i  (DIV_W'(p_q)),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_zero_o (div_rz)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (i_q == MaxL) state_d = ST_SV_RD;
      end
      ST_SV_RD: state_d = ST_SV_TEST;
      ST_SV_TEST: begin
        if (!map_rdata && (i_twice <= MaxL)) begin
          state_d = ST_SV_MARK;
        end else if (i_q == MaxL) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SV_RD;
        end
      end
      ST_SV_MARK: begin
        if (j_next > MaxL) begin
          state_d = (i_q == MaxL) ? ST_IDLE : ST_SV_RD;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_NEXT;
      end
      ST_NEXT:    state_d = cont ? ST_PR_RD : ST_FINAL;
      ST_PR_RD:   state_d = ST_PR_WAIT;
      ST_PR_WAIT: state_d = ST_DIV_GO;
      ST_DIV_GO:  state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (div_rz)       state_d = ST_DIV_GO;
          else if (found_q) state_d = ST_EMIT;
          else              state_d = ST_NEXT;
        end
      end
      ST_EMIT: begin
        if (!pend_v_q || out_free) state_d = ST_NEXT;
      end
      ST_FINAL: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // datapath and control
  always_comb begin
    i_d        = i_q;
    j_d        = j_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    rem_d      = rem_q;
    p_d        = p_q;
    found_d    = found_q;
    n_d        = n_q;
    pend_v_d   = pend_v_q;
    pend_k_d   = pend_k_q;
    pend_p_d   = pend_p_q;
    out_v_d    = out_v_q && out_stall_i;
    out_idx_d  = out_idx_q;
    out_val_d  = out_val_q;
    out_has_d  = out_has_q;
    out_last_d = out_last_q;
    map_we     = 1'b0;
    map_wd     = 1'b0;
    map_wa     = i_q[VAL_W-1:0];
    map_ra     = i_q[VAL_W-1:0];
    pl_we      = 1'b0;
    div_start  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        map_we = 1'b1;
        i_d    = (i_q == MaxL) ? (VAL_W + 1)'(2) : i_q + 1'b1;
      end
      ST_SV_RD: ;
      ST_SV_TEST: begin
        if (!map_rdata) begin
          if (cnt_q < DepL) begin
            pl_we = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
        end
        j_d = i_twice;
        if (map_rdata || (i_twice > MaxL)) begin
          if (i_q != MaxL) i_d = i_q + 1'b1;
        end
      end
      ST_SV_MARK: begin
        map_we = 1'b1;
        map_wd = 1'b1;
        map_wa = j_q[VAL_W-1:0];
        j_d    = j_next;
        if ((j_next > MaxL) && (i_q != MaxL)) i_d = i_q + 1'b1;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          rem_d    = value_i;
          k_d      = '0;
          n_d      = '0;
          pend_v_d = 1'b0;
        end
      end
      ST_NEXT: found_d = 1'b0;
      ST_PR_RD: ;
      ST_PR_WAIT: p_d = pl_rdata;
      ST_DIV_GO: div_start = 1'b1;
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (div_rz) begin
            rem_d   = div_quot;
            found_d = 1'b1;
          end else if (!found_q) begin
            k_d = k_q + 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            out_v_d    = 1'b1;
            out_idx_d  = INDEX_W'(pend_k_q);
            out_val_d  = VALUE_W'(DIV_W'(pend_p_q));
            out_has_d  = 1'b1;
            out_last_d = 1'b0;
          end
          pend_v_d = 1'b1;
          pend_k_d = k_q;
          pend_p_d = p_q;
          n_d      = n_q + 1'b1;
          k_d      = k_q + 1'b1;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_last_d = 1'b1;
          out_has_d  = pend_v_q;
          out_idx_d  = pend_v_q ? INDEX_W'(pend_k_q) : '0;
          out_val_d  = pend_v_q ? VALUE_W'(DIV_W'(pend_p_q)) : '0;
          pend_v_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      i_q      <= '0;
      j_q      <= '0;
      cnt_q    <= '0;
      k_q      <= '0;
      found_q  <= 1'b0;
      n_q      <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      j_q      <= j_d;
      cnt_q    <= cnt_d;
      k_q      <= k_d;
      found_q  <= found_d;
      n_q      <= n_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    p_q        <= p_d;
    pend_k_q   <= pend_k_d;
    pend_p_q   <= pend_p_d;
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_has_q  <= out_has_d;
    out_last_q <= out_last_d;
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_v_q;
  assign prime_index_o = out_idx_q;
  assign prime_value_o = out_val_q;
  assign has_factor_o  = out_has_q;
  assign last_o        = out_last_q;

endmodule
